FILE: hdl/ilsi_pkg.sv
package ilsi_pkg;

    // Request codes carried on the op field.
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_WRITE  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Fixed widths of the port fields.
    localparam int IDX_BITS   = 7;
    localparam int OUT_WORD_W = 32;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic shift_up;    // insert: cells above the target take the lower neighbor
        logic shift_down;  // remove: cells at or above the target take the upper neighbor
        logic load;        // append or write: the target cell takes the new word
        logic rd_load;     // read start: the target cell copies its word to the read line
        logic rd_shift;    // read line moves one cell toward cell zero
    } ilsi_cell_ctrl_t;

endpackage

FILE: hdl/ilsi_cell.sv
module ilsi_cell
    import ilsi_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int CMP_W     = 7,
    parameter int POS       = 0
)
(
    input  logic                 clk,
    input  ilsi_cell_ctrl_t      ctrl,
    input  logic [CMP_W-1:0]     tgt,
    input  logic [WORD_BITS-1:0] value,
    input  logic [WORD_BITS-1:0] prev_data,
    input  logic [WORD_BITS-1:0] next_data,
    input  logic [WORD_BITS-1:0] next_rd,
    output logic [WORD_BITS-1:0] data,
    output logic [WORD_BITS-1:0] rd
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(POS);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic [WORD_BITS-1:0] rd_reg;
    logic [WORD_BITS-1:0] rd_next;
    logic                 at_tgt;
    logic                 above_tgt;

    assign at_tgt    = (MY_POS == tgt);
    assign above_tgt = (MY_POS > tgt);

    // Entry update: shift up, shift down, load or hold.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_up)
        begin
            if (above_tgt)
            begin
                data_next = prev_data;
            end
            else if (at_tgt)
            begin
                data_next = value;
            end
        end
        else if (ctrl.shift_down)
        begin
            if (above_tgt || at_tgt)
            begin
                data_next = next_data;
            end
        end
        else if (ctrl.load && at_tgt)
        begin
            data_next = value;
        end
    end

    // Read line: the target cell drops its word in, then the line moves down.
    always_comb
    begin
        rd_next = rd_reg;
        if (ctrl.rd_load)
        begin
            rd_next = at_tgt ? data_reg : '0;
        end
        else if (ctrl.rd_shift)
        begin
            rd_next = next_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data = data_reg;
    assign rd   = rd_reg;

endmodule

FILE: hdl/indexed_list_shift_insert.sv
// Bounded ordered list of DEPTH words kept in a row of cells, one entry per
// cell, with a fill count. For append, insert, remove, write and clear, every
// cell shifts, loads or holds at once, and the result is offered in the cycle
// after the request is taken. On a successful read the word leaves its cell
// on a read line that moves one cell per cycle toward cell zero, and then
// passes from cell zero into the result register. No request is taken while
// a read is in flight. A rejected read is answered in the cycle after it is
// taken. A new request is taken while an earlier result waits, as long as
// that result is taken in the same cycle. Entries hold WORD_BITS bits;
// read_word shows the low 32 bits and fill_count the low 7 bits of the count.
module indexed_list_shift_insert
    import ilsi_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            op,
    input  logic [IDX_BITS-1:0]   index,
    input  logic [OUT_WORD_W-1:0] value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  ok,
    output logic [OUT_WORD_W-1:0] read_word,
    output logic [IDX_BITS-1:0]   fill_count,
    output logic                  is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;
    localparam int WW    = (WORD_BITS > OUT_WORD_W) ? WORD_BITS : OUT_WORD_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CMP_W-1:0]      rd_left_reg;
    logic [CMP_W-1:0]      rd_left_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  ok_reg;
    logic                  ok_next;
    logic [OUT_WORD_W-1:0] word_reg;
    logic [OUT_WORD_W-1:0] word_next;
    logic [CMP_W-1:0]      fill_reg;
    logic [CMP_W-1:0]      fill_next;

    logic                  accept;
    logic                  full;
    logic [CMP_W-1:0]      idx_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  req_ok;
    logic [CNT_W-1:0]      req_count;
    logic                  req_read;
    logic [CMP_W-1:0]      tgt;
    ilsi_cell_ctrl_t       ctrl;
    logic [WORD_BITS-1:0]  cell_value;
    logic [WW-1:0]         rd_wide;

    logic [WORD_BITS-1:0]  data_w [DEPTH];
    logic [WORD_BITS-1:0]  rd_w   [DEPTH];

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign idx_ext    = CMP_W'(index);
    assign cnt_ext    = CMP_W'(count_reg);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign cell_value = WORD_BITS'(value);
    assign rd_wide    = WW'(rd_w[0]);

    // Request decode: success, new count and target position.
    always_comb
    begin
        req_ok    = 1'b0;
        req_count = count_reg;
        req_read  = 1'b0;
        tgt       = idx_ext;
        case (op)
            OP_APPEND:
            begin
                tgt = cnt_ext;
                if (!full)
                begin
                    req_ok    = 1'b1;
                    req_count = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (!full && (idx_ext <= cnt_ext))
                begin
                    req_ok    = 1'b1;
                    req_count = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (idx_ext < cnt_ext)
                begin
                    req_ok    = 1'b1;
                    req_count = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                req_ok   = (idx_ext < cnt_ext);
                req_read = 1'b1;
            end
            OP_WRITE:
            begin
                req_ok = (idx_ext < cnt_ext);
            end
            OP_CLEAR:
            begin
                req_ok    = 1'b1;
                req_count = '0;
            end
            default:
            begin
                req_ok = 1'b0;
            end
        endcase
    end

    // Sequencer: commands to the cells, read countdown and result register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_left_next   = rd_left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        word_next      = word_reg;
        fill_next      = fill_reg;
        ctrl           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.shift_up   = req_ok && (op == OP_INSERT);
                    ctrl.shift_down = req_ok && (op == OP_REMOVE);
                    ctrl.load       = req_ok && ((op == OP_APPEND) || (op == OP_WRITE));
                    count_next      = req_count;
                    if (req_read && req_ok)
                    begin
                        ctrl.rd_load = 1'b1;
                        rd_left_next = idx_ext;
                        state_next   = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        ok_next        = req_ok;
                        word_next      = '0;
                        fill_next      = CMP_W'(req_count);
                    end
                end
            end
            ST_READ:
            begin
                if (rd_left_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    word_next      = rd_wide[OUT_WORD_W-1:0];
                    fill_next      = cnt_ext;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ctrl.rd_shift = 1'b1;
                    rd_left_next  = rd_left_reg - CMP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        word_reg <= word_next;
        fill_reg <= fill_next;
    end

    // Row of entry cells; each sees its neighbors, cell zero itself below, the top one zeros above.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] prev_d;
        logic [WORD_BITS-1:0] next_d;
        logic [WORD_BITS-1:0] next_r;

        if (i == 0)
        begin : g_first
            assign prev_d = data_w[0];
        end
        else
        begin : g_mid
            assign prev_d = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = '0;
            assign next_r = '0;
        end
        else
        begin : g_inner
            assign next_d = data_w[i+1];
            assign next_r = rd_w[i+1];
        end

        ilsi_cell #(
            .WORD_BITS (WORD_BITS),
            .CMP_W     (CMP_W),
            .POS       (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .tgt       (tgt),
            .value     (cell_value),
            .prev_data (prev_d),
            .next_data (next_d),
            .next_rd   (next_r),
            .data      (data_w[i]),
            .rd        (rd_w[i])
        );
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign read_word  = word_reg;
    assign fill_count = fill_reg[IDX_BITS-1:0];
    assign is_empty   = (fill_reg == '0);

    // A read in flight never overlaps a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("read in flight while a result is pending");

    // The fill count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // A successful append grows the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_APPEND) && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the count");

    // Requests are taken only while no read is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("request taken during a read");

endmodule

FILE: tb/indexed_list_shift_insert_test.sv
`timescale 1ns / 100ps

module indexed_list_shift_insert_test;
    import ilsi_pkg::*;

    localparam int LIST_DEPTH = 64;

    // The two codes the block ignores.
    localparam logic [2:0] OP_SPARE_SIX   = 3'd6;
    localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;

    // Kinds of random stretches in the request stream.
    localparam int RUN_FILL  = 0;
    localparam int RUN_DRAIN = 1;
    localparam int RUN_MIXED = 2;
    localparam int RUN_NOISE = 3;

    typedef struct packed {
        logic [2:0]            op;
        logic [IDX_BITS-1:0]   idx;
        logic [OUT_WORD_W-1:0] word;
    } list_request_t;

    typedef struct packed {
        logic                  ok;
        logic [OUT_WORD_W-1:0] read_word;
        logic [IDX_BITS-1:0]   fill_count;
        logic                  is_empty;
    } list_answer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            op = OP_APPEND;
    logic [IDX_BITS-1:0]   index = '0;
    logic [OUT_WORD_W-1:0] value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  ok;
    logic [OUT_WORD_W-1:0] read_word;
    logic [IDX_BITS-1:0]   fill_count;
    logic                  is_empty;

    // Predicted contents of the list.
    logic [OUT_WORD_W-1:0] shadow_words [LIST_DEPTH];
    int                    shadow_count = 0;

    list_request_t pending_requests [$];
    list_answer_t  expected_answers [$];

    int mismatch_count = 0;
    int requests_taken = 0;
    int planned_count  = 0;

    // Sender and receiver pacing.
    int burst_left  = 0;
    int send_gap    = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    list_request_t taken_request;
    list_request_t next_request;
    list_answer_t  oldest_answer;

    indexed_list_shift_insert dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .read_word  (read_word),
        .fill_count (fill_count),
        .is_empty   (is_empty)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one request to the shadow list and return the answer it should get.
    function automatic list_answer_t apply_list_request(list_request_t rq);
        list_answer_t ans;
        int           pos;
        int           i;
        pos = rq.idx;
        ans = '0;
        case (rq.op)
            OP_APPEND:
            begin
                if (shadow_count < LIST_DEPTH)
                begin
                    shadow_words[shadow_count] = rq.word;
                    shadow_count++;
                    ans.ok = 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (pos <= shadow_count && shadow_count < LIST_DEPTH)
                begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = rq.word;
                    shadow_count++;
                    ans.ok = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos < shadow_count)
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                    ans.ok = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos < shadow_count)
                begin
                    ans.read_word = shadow_words[pos];
                    ans.ok = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (pos < shadow_count)
                begin
                    shadow_words[pos] = rq.word;
                    ans.ok = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                ans.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        ans.fill_count = shadow_count[IDX_BITS-1:0];
        ans.is_empty = (shadow_count == 0);
        return ans;
    endfunction

    // Queue a request and track the fill count it leaves, so the random
    // stream can aim its indexes at the live part of the list.
    task automatic queue_request(logic [2:0] code, int pos, logic [OUT_WORD_W-1:0] word);
        list_request_t rq;
        rq.op = code;
        rq.idx = pos[IDX_BITS-1:0];
        rq.word = word;
        pending_requests.push_back(rq);
        case (code)
            OP_APPEND: if (planned_count < LIST_DEPTH) planned_count++;
            OP_INSERT: if (pos <= planned_count && planned_count < LIST_DEPTH) planned_count++;
            OP_REMOVE: if (pos < planned_count) planned_count--;
            OP_CLEAR:  planned_count = 0;
            default:   ;
        endcase
    endtask

    // Mostly a position inside the list (or one past it), now and then any index.
    function automatic int pick_index(bit allow_end);
        int top;
        top = allow_end ? planned_count : planned_count - 1;
        if (top < 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(0, top);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: take the accepted transaction into the prediction, then offer the
    // next pending request in bursts with gaps between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken_request.op = op;
                taken_request.idx = index;
                taken_request.word = value;
                expected_answers.push_back(apply_list_request(taken_request));
                requests_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_request = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    op <= next_request.op;
                    index <= next_request.idx;
                    value <= next_request.word;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: one long hold-off once traffic is flowing, otherwise a
    // changing mix of always ready, coin-flip and mostly stalled stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && requests_taken >= 300)
        begin
            hold_done = 1'b1;
            hold_left = 250;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", {31'd0, ok}, 32'd0);
            end
            else
            begin
                oldest_answer = expected_answers.pop_front();
                if (ok !== oldest_answer.ok)
                    report_mismatch("ok", {31'd0, ok}, {31'd0, oldest_answer.ok});
                if (read_word !== oldest_answer.read_word)
                    report_mismatch("read_word", read_word, oldest_answer.read_word);
                if (fill_count !== oldest_answer.fill_count)
                    report_mismatch("fill_count", {25'd0, fill_count},
                                    {25'd0, oldest_answer.fill_count});
                if (is_empty !== oldest_answer.is_empty)
                    report_mismatch("is_empty", {31'd0, is_empty},
                                    {31'd0, oldest_answer.is_empty});
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int run_kind;
        int run_len;
        int n;
        int roll;

        // Empty list: everything but append, insert at zero and clear is refused.
        queue_request(OP_READ, 0, 32'h1234_5678);
        queue_request(OP_REMOVE, 0, 32'h0);
        queue_request(OP_WRITE, 0, 32'hDEAD_BEEF);
        queue_request(OP_INSERT, 1, 32'h1111_1111);
        queue_request(OP_INSERT, 0, 32'h0000_0000);
        queue_request(OP_APPEND, 0, 32'hFFFF_FFFF);
        queue_request(OP_APPEND, 127, 32'h5A5A_A5A5);
        // Insert at the count lands at the end; then one in the middle.
        queue_request(OP_INSERT, 3, 32'hA5A5_5A5A);
        queue_request(OP_INSERT, 1, $urandom());
        queue_request(OP_READ, 0, 32'hFFFF_FFFF);
        queue_request(OP_READ, 4, 32'h0);
        queue_request(OP_READ, 5, 32'h0);
        queue_request(OP_READ, 127, 32'h0);
        queue_request(OP_WRITE, 2, 32'hFFFF_FFFF);
        queue_request(OP_WRITE, 127, 32'h8000_0001);
        queue_request(OP_READ, 2, 32'h0);
        queue_request(OP_REMOVE, 4, 32'h0);
        queue_request(OP_REMOVE, 0, 32'h0);
        queue_request(OP_REMOVE, 1, 32'h0);
        queue_request(OP_INSERT, 64, 32'h7777_7777);
        queue_request(OP_SPARE_SIX, 0, 32'hFFFF_FFFF);
        queue_request(OP_SPARE_SEVEN, 127, 32'h0);
        queue_request(OP_CLEAR, 0, 32'h0);
        queue_request(OP_APPEND, 0, $urandom());
        queue_request(OP_READ, 0, 32'h0);

        // Random stretches: fill to the top, drain to empty, mixed traffic
        // inside the list, and some plain noise.
        while (pending_requests.size() < 1025)
        begin
            roll = $urandom_range(0, 9);
            run_kind = (roll < 3) ? RUN_FILL : (roll < 5) ? RUN_DRAIN :
                       (roll < 9) ? RUN_MIXED : RUN_NOISE;
            run_len = $urandom_range(5, 80);
            for (n = 0; n < run_len; n++)
            begin
                roll = $urandom_range(0, 99);
                case (run_kind)
                    RUN_FILL:
                    begin
                        if (roll < 45)
                            queue_request(OP_APPEND, $urandom_range(0, 127), $urandom());
                        else if (roll < 80)
                            queue_request(OP_INSERT, pick_index(1'b1), $urandom());
                        else if (roll < 90)
                            queue_request(OP_READ, pick_index(1'b0), $urandom());
                        else
                            queue_request(OP_WRITE, pick_index(1'b0), $urandom());
                    end
                    RUN_DRAIN:
                    begin
                        if (roll < 70)
                            queue_request(OP_REMOVE, pick_index(1'b0), $urandom());
                        else if (roll < 85)
                            queue_request(OP_READ, pick_index(1'b0), $urandom());
                        else if (roll < 98)
                            queue_request(OP_WRITE, pick_index(1'b0), $urandom());
                        else
                            queue_request(OP_CLEAR, $urandom_range(0, 127), $urandom());
                    end
                    RUN_MIXED:
                    begin
                        if (roll < 15)
                            queue_request(OP_APPEND, $urandom_range(0, 127), $urandom());
                        else if (roll < 30)
                            queue_request(OP_INSERT, pick_index(1'b1), $urandom());
                        else if (roll < 45)
                            queue_request(OP_REMOVE, pick_index(1'b0), $urandom());
                        else if (roll < 75)
                            queue_request(OP_READ, pick_index(1'b0), $urandom());
                        else if (roll < 98)
                            queue_request(OP_WRITE, pick_index(1'b0), $urandom());
                        else
                            queue_request(OP_CLEAR, $urandom_range(0, 127), $urandom());
                    end
                    default:
                    begin
                        queue_request(3'($urandom_range(0, 7)), $urandom_range(0, 127),
                                      $urandom());
                    end
                endcase
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ilsi_pkg.sv
hdl/ilsi_cell.sv
hdl/indexed_list_shift_insert.sv
tb/indexed_list_shift_insert_test.sv
